/* rtl/vertex_rotate_project_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the vertex rotate and project core.
// Shared same-cycle-implication and next-cycle-implication checks.
// ----------------------------------------------------------------------------
`ifndef VERTEX_ROTATE_PROJECT_CORE_MACROS_SVH
`define VERTEX_ROTATE_PROJECT_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VRP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vertex core check failed");

// The consequent must hold in the cycle after the antecedent.
`define VRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vertex core check failed");

`endif

/* rtl/vrp_pkg.sv */
// ----------------------------------------------------------------------------
// vrp_pkg
// Types, register codes and reset values of the vertex rotate and project core.
// ----------------------------------------------------------------------------
package vrp_pkg;

   localparam int PROJ_SCALE_DEF = 100;

   localparam logic signed [15:0] COS_RESET    = 16'sd16384;
   localparam logic signed [15:0] SIN_RESET    = 16'sd0;
   localparam logic        [15:0] FOV_RESET    = 16'd256;
   localparam logic        [13:0] WIDTH_RESET  = 14'd640;
   localparam logic        [13:0] HEIGHT_RESET = 14'd480;

   // Register codes, taken from the word address.
   typedef enum logic [2:0] {
      CSR_COS    = 3'd0,
      CSR_SIN    = 3'd1,
      CSR_FOV    = 3'd2,
      CSR_WIDTH  = 3'd3,
      CSR_HEIGHT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] pz;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic               behind_viewer;
   } rsp_item_type;

endpackage

/* rtl/vrp_div.sv */
// ----------------------------------------------------------------------------
// vrp_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vrp_div #(
   parameter int AW  = 37,
   parameter int DW  = 20,
   parameter int SBW = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  logic           in_valid,
   input  logic [AW-1:0]  dividend,
   input  logic [DW-1:0]  divisor,
   input  logic [SBW-1:0] in_side,
   output logic           out_valid,
   output logic [AW-1:0]  quotient,
   output logic [SBW-1:0] out_side
);

   logic           vld_ff [AW];
   logic [DW-1:0]  rem_ff [AW];
   logic [AW-1:0]  wrk_ff [AW];
   logic [DW-1:0]  dvs_ff [AW];
   logic [SBW-1:0] sd_ff  [AW];

   for (genvar k = 0; k < AW; k++) begin : g_stage
      logic           prev_vld;
      logic [DW-1:0]  prev_rem;
      logic [AW-1:0]  prev_wrk;
      logic [DW-1:0]  prev_dvs;
      logic [SBW-1:0] prev_sd;
      logic [DW:0]    trial;
      logic           fits;

      if (k == 0) begin : g_first
         assign prev_vld = in_valid;
         assign prev_rem = '0;
         assign prev_wrk = dividend;
         assign prev_dvs = divisor;
         assign prev_sd  = in_side;
      end else begin : g_next
         assign prev_vld = vld_ff[k-1];
         assign prev_rem = rem_ff[k-1];
         assign prev_wrk = wrk_ff[k-1];
         assign prev_dvs = dvs_ff[k-1];
         assign prev_sd  = sd_ff[k-1];
      end

      // Bring down the next dividend bit and subtract when the divisor fits.
      assign trial = {prev_rem, prev_wrk[AW-1]};
      assign fits  = trial >= {1'b0, prev_dvs};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (enable) begin
            vld_ff[k] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= fits ? DW'(trial - {1'b0, prev_dvs}) : DW'(trial);
            wrk_ff[k] <= {prev_wrk[AW-2:0], fits};
            dvs_ff[k] <= prev_dvs;
            sd_ff[k]  <= prev_sd;
         end
      end
   end

   assign out_valid = vld_ff[AW-1];
   assign quotient  = wrk_ff[AW-1];
   assign out_side  = sd_ff[AW-1];

endmodule

/* rtl/vertex_rotate_project_core.sv */
// ----------------------------------------------------------------------------
// vertex_rotate_project_core
// Rotates a Q8.8 point about Y then X and projects it in perspective.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   -------   --------------------   --------------------------------------
//   req       req_valid, req_stall   req_item: px, py, pz (Q8.8)
//   rsp       rsp_valid, rsp_stall   rsp_item: screen_x, screen_y, behind
//   csr       psel, penable, pready  paddr, pwdata, prdata (32-bit words)
//
// The core accepts one item per clock while the receiver does not stall.
// DIV_W = 30 + clog2(PROJ_SCALE + 1) is the quotient width, and the divider
// pipeline works one quotient bit per stage.
// Reset is synchronous and clears the valid bits and the registers to their
// documented defaults. The whole pipeline advances as one: it holds whenever
// a finished item sits in the output register and the receiver stalls.
//
// Stage plan:
//   1  four rotation products about Y
//   2  x1, z1 (shift down by 14, floor)
//   3  four rotation products about X
//   4  y2, z2
//   5  d = fov + z2, the behind-viewer flag, x1*fov and y2*fov
//   6  multiply by the projection scale
//   7  magnitude and sign; divide by 256 folded into a shift
//   8+ two restoring dividers by d, then center, saturate and register.
//
`include "vertex_rotate_project_core_macros.svh"

module vertex_rotate_project_core #(
   parameter int PROJ_SCALE = vrp_pkg::PROJ_SCALE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  vrp_pkg::req_item_type req_item,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output vrp_pkg::rsp_item_type rsp_item,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [4:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   // Widths that follow from the projection scale.
   localparam int SCALE_W = $clog2(PROJ_SCALE + 1);
   localparam int NUM_W   = 38 + SCALE_W;
   localparam int DIV_W   = NUM_W - 8;
   localparam logic signed [SCALE_W:0] SCALE_S = (SCALE_W + 1)'(PROJ_SCALE);
   localparam logic signed [DIV_W+1:0] SAT_MAX = (DIV_W + 2)'(32767);
   localparam logic signed [DIV_W+1:0] SAT_MIN = ~SAT_MAX;

   // ------------------------------------------------------------------------
   // Configuration registers. Writes complete in the APB access phase.
   // ------------------------------------------------------------------------
   logic signed [15:0] cos_ff;
   logic signed [15:0] sin_ff;
   logic        [15:0] fov_ff;
   logic        [13:0] width_ff;
   logic        [13:0] height_ff;
   vrp_pkg::csr_index_type csr_index;
   logic                   csr_write;

   assign pready    = 1'b1;
   assign csr_index = vrp_pkg::csr_index_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff    <= vrp_pkg::COS_RESET;
         sin_ff    <= vrp_pkg::SIN_RESET;
         fov_ff    <= vrp_pkg::FOV_RESET;
         width_ff  <= vrp_pkg::WIDTH_RESET;
         height_ff <= vrp_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            vrp_pkg::CSR_COS:    cos_ff    <= pwdata[15:0];
            vrp_pkg::CSR_SIN:    sin_ff    <= pwdata[15:0];
            vrp_pkg::CSR_FOV:    fov_ff    <= pwdata[15:0];
            vrp_pkg::CSR_WIDTH:  width_ff  <= pwdata[13:0];
            vrp_pkg::CSR_HEIGHT: height_ff <= pwdata[13:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         vrp_pkg::CSR_COS:    prdata = {16'd0, cos_ff};
         vrp_pkg::CSR_SIN:    prdata = {16'd0, sin_ff};
         vrp_pkg::CSR_FOV:    prdata = {16'd0, fov_ff};
         vrp_pkg::CSR_WIDTH:  prdata = {18'd0, width_ff};
         vrp_pkg::CSR_HEIGHT: prdata = {18'd0, height_ff};
         default:             prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Flow control. Every stage moves when the output register is free or is
   // being taken this cycle, so an item is never dropped or duplicated.
   // ------------------------------------------------------------------------
   logic                  rsp_valid_ff;
   vrp_pkg::rsp_item_type rsp_item_ff;
   logic                  advance;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Stage 1: rotation about Y, products.
   logic               v1_ff;
   logic signed [31:0] cx1_ff, sz1_ff, sx1_ff, cz1_ff;
   logic signed [15:0] y1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cx1_ff <= cos_ff * req_item.px;
         sz1_ff <= sin_ff * req_item.pz;
         sx1_ff <= sin_ff * req_item.px;
         cz1_ff <= cos_ff * req_item.pz;
         y1_ff  <= req_item.py;
      end
   end

   // Stage 2: x1 and z1. An arithmetic shift is the floor of the quotient.
   logic               v2_ff;
   logic signed [19:0] x2_ff, z2r_ff;
   logic signed [15:0] y2p_ff;
   logic signed [32:0] x1_sum, z1_sum;

   assign x1_sum = 33'(cx1_ff) - 33'(sz1_ff);
   assign z1_sum = 33'(sx1_ff) + 33'(cz1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x2_ff  <= 20'(x1_sum >>> 14);
         z2r_ff <= 20'(z1_sum >>> 14);
         y2p_ff <= y1_ff;
      end
   end

   // Stage 3: rotation about X, products.
   logic               v3_ff;
   logic signed [35:0] cy3_ff, sz3_ff, sy3_ff, cz3_ff;
   logic signed [19:0] x3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cy3_ff <= cos_ff * y2p_ff;
         sz3_ff <= sin_ff * z2r_ff;
         sy3_ff <= sin_ff * y2p_ff;
         cz3_ff <= cos_ff * z2r_ff;
         x3_ff  <= x2_ff;
      end
   end

   // Stage 4: y2 and z2.
   logic               v4_ff;
   logic signed [19:0] x4_ff, y4_ff, z4_ff;
   logic signed [36:0] y2_sum, z2_sum;

   assign y2_sum = 37'(cy3_ff) - 37'(sz3_ff);
   assign z2_sum = 37'(sy3_ff) + 37'(cz3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x4_ff <= x3_ff;
         y4_ff <= 20'(y2_sum >>> 14);
         z4_ff <= 20'(z2_sum >>> 14);
      end
   end

   // Stage 5: depth, the behind-viewer test and the products with fov.
   logic               v5_ff;
   logic signed [36:0] mx5_ff, my5_ff;
   logic        [19:0] d5_ff;
   logic               behind5_ff;
   logic signed [20:0] depth;
   logic signed [16:0] fov_s;

   assign fov_s = $signed({1'b0, fov_ff});
   assign depth = 21'(z4_ff) + 21'(fov_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mx5_ff     <= x4_ff * fov_s;
         my5_ff     <= y4_ff * fov_s;
         d5_ff      <= depth[19:0];
         behind5_ff <= depth[20] || (depth == '0);
      end
   end

   // Stage 6: scale by the projection constant.
   logic                   v6_ff;
   logic signed [NUM_W-1:0] nx6_ff, ny6_ff;
   logic        [19:0]     d6_ff;
   logic                   behind6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (advance) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         nx6_ff     <= mx5_ff * SCALE_S;
         ny6_ff     <= my5_ff * SCALE_S;
         d6_ff      <= d5_ff;
         behind6_ff <= behind5_ff;
      end
   end

   // Stage 7: magnitudes. Truncation toward zero divides the magnitude and
   // restores the sign afterwards; the factor of 256 is a plain shift.
   logic              v7_ff;
   logic [DIV_W-1:0]  ax7_ff, ay7_ff;
   logic              sx7_ff, sy7_ff;
   logic [19:0]       d7_ff;
   logic              behind7_ff;
   logic [NUM_W-1:0]  mag_x, mag_y;

   assign mag_x = nx6_ff[NUM_W-1] ? NUM_W'(-nx6_ff) : NUM_W'(nx6_ff);
   assign mag_y = ny6_ff[NUM_W-1] ? NUM_W'(-ny6_ff) : NUM_W'(ny6_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (advance) begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ax7_ff     <= mag_x[NUM_W-1:8];
         ay7_ff     <= mag_y[NUM_W-1:8];
         sx7_ff     <= nx6_ff[NUM_W-1];
         sy7_ff     <= ny6_ff[NUM_W-1];
         d7_ff      <= d6_ff;
         behind7_ff <= behind6_ff;
      end
   end

   // Dividers. The x divider carries the valid bit and the behind flag.
   logic             qx_valid, qy_valid;
   logic [DIV_W-1:0] qx, qy;
   logic [1:0]       qx_side;
   logic             qy_side;

   vrp_div #(
      .AW  (DIV_W),
      .DW  (20),
      .SBW (2)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (v7_ff),
      .dividend  (ax7_ff),
      .divisor   (d7_ff),
      .in_side   ({behind7_ff, sx7_ff}),
      .out_valid (qx_valid),
      .quotient  (qx),
      .out_side  (qx_side)
   );

   vrp_div #(
      .AW  (DIV_W),
      .DW  (20),
      .SBW (1)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (v7_ff),
      .dividend  (ay7_ff),
      .divisor   (d7_ff),
      .in_side   (sy7_ff),
      .out_valid (qy_valid),
      .quotient  (qy),
      .out_side  (qy_side)
   );

   // Final stage: restore signs, add the screen center and saturate.
   logic signed [DIV_W:0]   off_x, off_y;
   logic signed [DIV_W+1:0] sum_x, sum_y;
   logic signed [15:0]      sat_x, sat_y;
   vrp_pkg::rsp_item_type   rsp_item_in;

   assign off_x = qx_side[0] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
   assign off_y = qy_side    ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
   assign sum_x = (DIV_W + 2)'(off_x) + $signed((DIV_W + 2)'(width_ff[13:1]));
   assign sum_y = (DIV_W + 2)'(off_y) + $signed((DIV_W + 2)'(height_ff[13:1]));

   always_comb begin
      if (sum_x > SAT_MAX) begin
         sat_x = 16'sh7fff;
      end else if (sum_x < SAT_MIN) begin
         sat_x = 16'sh8000;
      end else begin
         sat_x = sum_x[15:0];
      end
      if (sum_y > SAT_MAX) begin
         sat_y = 16'sh7fff;
      end else if (sum_y < SAT_MIN) begin
         sat_y = 16'sh8000;
      end else begin
         sat_y = sum_y[15:0];
      end
   end

   always_comb begin
      rsp_item_in.behind_viewer = qx_side[1];
      if (qx_side[1]) begin
         rsp_item_in.screen_x = '0;
         rsp_item_in.screen_y = '0;
      end else begin
         rsp_item_in.screen_x = sat_x;
         rsp_item_in.screen_y = sat_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= qx_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ------------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------------
   `VRP_ASSERT_NOW(a_behind_zero, clock, reset, rsp_valid && rsp_item.behind_viewer,
                   rsp_item.screen_x == 16'sd0 && rsp_item.screen_y == 16'sd0)
   `VRP_ASSERT_NOW(a_stall_source, clock, reset, 1'b1,
                   req_stall == (rsp_valid && rsp_stall))
   `VRP_ASSERT_NEXT(a_pipe_hold, clock, reset, req_stall,
                    $stable(v7_ff) && $stable(ax7_ff))
   `VRP_ASSERT_NOW(a_div_lockstep, clock, reset, 1'b1, qx_valid == qy_valid)

endmodule

/* verif/vrp_projection_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vrp_projection_checker
// Watches the point and screen channels and the register port of the vertex
// core. It predicts each screen item from its own copy of the view registers
// and compares the predictions with the core's items field by field.
// ----------------------------------------------------------------------------
module vrp_projection_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  vrp_pkg::req_item_type req_item,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  vrp_pkg::rsp_item_type rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [4:0]            paddr,
   input  logic [31:0]           pwdata,
   output int                    mismatch_count,
   output int                    pending_count
);

   logic signed [15:0] view_cos;
   logic signed [15:0] view_sin;
   logic        [15:0] view_fov;
   logic        [13:0] view_width;
   logic        [13:0] view_height;

   vrp_pkg::rsp_item_type screen_q[$];

   function automatic longint clamp16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Rotation about Y then X in Q2.14, then the perspective divide.
   function automatic vrp_pkg::rsp_item_type project_point(input vrp_pkg::req_item_type p);
      longint x, y, z, c, s, x1, z1, y2, z2, f, d, sx, sy;
      vrp_pkg::rsp_item_type r;
      x = $signed(p.px);
      y = $signed(p.py);
      z = $signed(p.pz);
      c = view_cos;
      s = view_sin;
      x1 = (c * x - s * z) >>> 14;
      z1 = (s * x + c * z) >>> 14;
      y2 = (c * y - s * z1) >>> 14;
      z2 = (s * y + c * z1) >>> 14;
      f = longint'(view_fov);
      d = f + z2;
      if (d <= 0) begin
         r.screen_x = '0;
         r.screen_y = '0;
         r.behind_viewer = 1'b1;
         return r;
      end
      sx = longint'(view_width / 2) + (vrp_pkg::PROJ_SCALE_DEF * f * x1) / (256 * d);
      sy = longint'(view_height / 2) + (vrp_pkg::PROJ_SCALE_DEF * f * y2) / (256 * d);
      r.screen_x = 16'(clamp16(sx));
      r.screen_y = 16'(clamp16(sy));
      r.behind_viewer = 1'b0;
      return r;
   endfunction

   assign pending_count = screen_q.size();

   always @(posedge clock) begin
      vrp_pkg::rsp_item_type want;
      if (reset) begin
         view_cos    <= vrp_pkg::COS_RESET;
         view_sin    <= vrp_pkg::SIN_RESET;
         view_fov    <= vrp_pkg::FOV_RESET;
         view_width  <= vrp_pkg::WIDTH_RESET;
         view_height <= vrp_pkg::HEIGHT_RESET;
         screen_q.delete();
         mismatch_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               vrp_pkg::CSR_COS:    view_cos    <= pwdata[15:0];
               vrp_pkg::CSR_SIN:    view_sin    <= pwdata[15:0];
               vrp_pkg::CSR_FOV:    view_fov    <= pwdata[15:0];
               vrp_pkg::CSR_WIDTH:  view_width  <= pwdata[13:0];
               vrp_pkg::CSR_HEIGHT: view_height <= pwdata[13:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            screen_q.push_back(project_point(req_item));
         if (rsp_valid && !rsp_stall) begin
            if (screen_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected screen item %p", rsp_item);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = screen_q.pop_front();
               if (want.screen_x !== rsp_item.screen_x ||
                   want.screen_y !== rsp_item.screen_y ||
                   want.behind_viewer !== rsp_item.behind_viewer) begin
                  if (mismatch_count < 10)
                     $display({"screen item: expected x=%0d y=%0d behind=%0b,",
                               " got x=%0d y=%0d behind=%0b"},
                              want.screen_x, want.screen_y, want.behind_viewer,
                              rsp_item.screen_x, rsp_item.screen_y,
                              rsp_item.behind_viewer);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

endmodule

/* verif/tb_vertex_rotate_project_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vertex_rotate_project_core
// Streams points through the vertex core under several view settings and
// traffic patterns; a checker beside the core predicts every screen item.
// ----------------------------------------------------------------------------
module tb_vertex_rotate_project_core;

   // Cycles without any item moving before the run is declared hung. The
   // longest quiet stretch is a settle pause plus the pipeline depth.
   localparam int HANG_LIMIT = 4000;
   // Settle pauses use a margin beyond the core's pipeline depth.
   localparam int SETTLE_CYCLES = 60;
   localparam int PHASE_POINTS = 250;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   vrp_pkg::req_item_type req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   vrp_pkg::rsp_item_type rsp_item;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [4:0]            paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   int mismatch_count;
   int pending_count;
   int stall_pct = 0;
   int quiet_cycles = 0;
   logic [15:0] fov_now = vrp_pkg::FOV_RESET;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   vertex_rotate_project_core u_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_item,
      .rsp_valid, .rsp_stall, .rsp_item,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   vrp_projection_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_item,
      .rsp_valid, .rsp_stall, .rsp_item,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .mismatch_count, .pending_count
   );

   // The receiver stalls at random with the percentage the current phase sets.
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // Hang detection: any accepted item on either channel resets the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == HANG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // One register write: a setup phase, then an access phase. The upper
   // data bits carry noise that the core must drop.
   task automatic csr_write(input logic [2:0] index, input logic [15:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= {16'($urandom_range(65535)), value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Waits until every screen item has arrived and the pipeline has drained.
   task automatic drain_core();
      while (pending_count != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Loads a complete view, plus a write to an unused register slot, which
   // the core must ignore.
   task automatic load_view(input logic [15:0] c, input logic [15:0] s,
                            input logic [15:0] f, input logic [13:0] w,
                            input logic [13:0] h);
      drain_core();
      csr_write(vrp_pkg::CSR_COS, c);
      csr_write(vrp_pkg::CSR_SIN, s);
      csr_write(vrp_pkg::CSR_FOV, f);
      csr_write(vrp_pkg::CSR_WIDTH, {2'b00, w});
      csr_write(vrp_pkg::CSR_HEIGHT, {2'b00, h});
      csr_write(3'($urandom_range(7, 5)), 16'($urandom_range(65535)));
      fov_now = f;
   endtask

   // Offers one point, with random gaps before it, and holds it until taken.
   task automatic send_point(input vrp_pkg::req_item_type p, input int gap_pct);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= p;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_coords(input int x, input int y, input int z);
      vrp_pkg::req_item_type p;
      p.px = 16'(x);
      p.py = 16'(y);
      p.pz = 16'(z);
      send_point(p, 0);
   endtask

   // Random points: full range for the largest share, many small ones that stay on screen,
   // and a share near the viewer plane where the depth sum crosses zero.
   function automatic vrp_pkg::req_item_type random_point();
      vrp_pkg::req_item_type p;
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         p = vrp_pkg::req_item_type'({$urandom, 16'($urandom_range(65535))});
      end else if (pick < 75) begin
         p.px = 16'($urandom_range(4095) - 2048);
         p.py = 16'($urandom_range(4095) - 2048);
         p.pz = 16'($urandom_range(4095) - 2048);
      end else begin
         p.px = 16'($urandom_range(2047) - 1024);
         p.py = 16'($urandom_range(2047) - 1024);
         p.pz = 16'(-int'(fov_now) + $urandom_range(64) - 32);
      end
      return p;
   endfunction

   task automatic run_phase(input int phase);
      int gap_pct;
      // Traffic pattern: free flowing, sender gaps, receiver stalls, both.
      case (phase % 4)
         0: begin gap_pct = 0;  stall_pct = 0;  end
         1: begin gap_pct = 77; stall_pct = 0;  end
         2: begin gap_pct = 0;  stall_pct = 77; end
         default: begin gap_pct = 26; stall_pct = 26; end
      endcase
      for (int i = 0; i < PHASE_POINTS; i++) begin
         // Once, the sender holds off until the core has emptied.
         if (phase == 3 && i == PHASE_POINTS / 2) begin
            req_valid <= 1'b0;
            while (pending_count != 0)
               @(negedge clock);
         end
         send_point(random_point(), gap_pct);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed points under the reset view: identity rotation, fov 1.0.
      send_coords(0, 0, 0);
      send_coords(32767, 32767, 32767);
      send_coords(-32768, -32768, -32768);
      send_coords(32767, -32768, 0);
      send_coords(-32768, 32767, 0);
      send_coords(256, 256, 0);
      // Depth sum exactly zero, and just either side of it.
      send_coords(100, 100, -256);
      send_coords(100, 100, -255);
      send_coords(100, 100, -257);
      // A point just in front of the viewer throws the result off screen.
      send_coords(32767, -32768, -255);
      send_coords(-32768, 32767, -255);
      send_coords(0, 0, -32768);
      send_coords(-1, -1, -1);
      send_coords(1, 1, 1);
      req_valid <= 1'b0;

      run_phase(0);
      // A quarter turn.
      load_view(16'd0, 16'd16384, 16'd256, 14'd640, 14'd480);
      run_phase(1);
      // A half turn with the largest fov and sizes of 8192.
      load_view(-16'sd16384, 16'd0, 16'hFFFF, 14'd8192, 14'd8192);
      run_phase(2);
      // Out-of-range registers: zero fov and sizes, cos and sin at the rails.
      load_view(16'h8000, 16'h7FFF, 16'd0, 14'd0, 14'd0);
      run_phase(3);
      // An eighth turn, the smallest fov, a full-width field.
      load_view(16'd11585, 16'd11585, 16'd1, 14'h3FFF, 14'd1);
      run_phase(4);
      for (int phase = 5; phase < 8; phase++) begin
         load_view(16'($urandom_range(32768) - 16384),
                   16'($urandom_range(32768) - 16384),
                   16'($urandom_range(65535, 1)),
                   14'($urandom_range(8192, 1)), 14'($urandom_range(8192, 1)));
         run_phase(phase);
      end

      stall_pct = 0;
      drain_core();
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
